// ----- sv/wvt_pkg.sv -----
package wvt_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned WEIGHT_W = 7;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned TALLY_W  = 16;
  localparam int unsigned USED_W   = 7;
  localparam int unsigned WORD_W   = ADDR_W + TALLY_W;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0]   reported_address;
    logic [WEIGHT_W-1:0] weight;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [TALLY_W-1:0] tally;
    logic               created;
    logic               dropped;
    logic [USED_W-1:0]  used_entries;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

// ----- sv/wvt_update.sv -----
module wvt_update #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                  hit_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        hit_idx_i,
  input  logic [wvt_pkg::TALLY_W-1:0]           hit_tally_i,
  input  wvt_pkg::in_t                          vote_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]      count_i,
  output logic                                  we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]        waddr_o,
  output logic [wvt_pkg::WORD_W-1:0]            wdata_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      count_o,
  output wvt_pkg::out_t                         result_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [wvt_pkg::TALLY_W:0]   sum;
  logic [wvt_pkg::TALLY_W-1:0] sat;
  logic                        has_room;

  assign sum = {1'b0, hit_tally_i} + (wvt_pkg::TALLY_W+1)'(vote_i.weight);
  assign sat = sum[wvt_pkg::TALLY_W] ? wvt_pkg::TALLY_MAX : sum[wvt_pkg::TALLY_W-1:0];
  assign has_room = count_i < DEPTH_C;

  always_comb begin
    we_o     = 1'b0;
    waddr_o  = hit_idx_i;
    wdata_o  = {vote_i.reported_address, sat};
    count_o  = count_i;
    result_o = '0;
    if (hit_i) begin
      we_o           = 1'b1;
      result_o.slot  = wvt_pkg::SLOT_W'(hit_idx_i);
      result_o.tally = sat;
    end else if (has_room) begin
      we_o             = 1'b1;
      waddr_o          = count_i[IW-1:0];
      wdata_o          = {vote_i.reported_address,
                          wvt_pkg::TALLY_W'(vote_i.weight)};
      count_o          = count_i + CW'(1);
      result_o.slot    = wvt_pkg::SLOT_W'(count_i);
      result_o.tally   = wvt_pkg::TALLY_W'(vote_i.weight);
      result_o.created = 1'b1;
    end else begin
      result_o.dropped = 1'b1;
    end
    result_o.used_entries = wvt_pkg::USED_W'(count_o);
  end

endmodule

// ----- sv/weighted_vote_tally_table.sv -----
// A vote scans the entries in order until one matches; a miss scans every entry
// in use, and with an empty table no entry is read.
// Throughput: one vote at a time; the single-port table scan, one entry per cycle
// through a shared 48-bit comparator, bounds the rate. A new input beat is taken
// once the previous result sits in the output register. Reset clears the entry
// count and control state only.
module weighted_vote_tally_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wvt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wvt_pkg::out_t out_data_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  wvt_pkg::state_e state_q, state_d;

  logic [wvt_pkg::WORD_W-1:0] mem [TABLE_DEPTH];
  logic [wvt_pkg::WORD_W-1:0] rdata_q;

  wvt_pkg::in_t  vote_q;
  wvt_pkg::out_t out_q;
  logic          out_valid_q, out_valid_d;

  logic [CW-1:0] count_q, count_d, upd_count;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] cmp_idx_q;
  logic          cmp_vld_q, cmp_vld_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [wvt_pkg::TALLY_W-1:0] hit_tally_q, hit_tally_d;

  logic issue_en, match, accept, out_free, commit;

  logic                       upd_we;
  logic [IW-1:0]              upd_waddr;
  logic [wvt_pkg::WORD_W-1:0] upd_wdata;
  wvt_pkg::out_t              upd_result;

  assign accept   = (state_q == wvt_pkg::ST_IDLE) && in_valid_i;
  assign issue_en = (state_q == wvt_pkg::ST_SCAN) && (rd_idx_q < count_q);
  assign match    = cmp_vld_q &&
                    (rdata_q[wvt_pkg::WORD_W-1:wvt_pkg::TALLY_W] == vote_q.reported_address);
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == wvt_pkg::ST_UPDATE) && out_free;

  assign in_stall_o  = (state_q != wvt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  wvt_update #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_update (
    .hit_i      (hit_q),
    .hit_idx_i  (hit_idx_q),
    .hit_tally_i(hit_tally_q),
    .vote_i     (vote_q),
    .count_i    (count_q),
    .we_o       (upd_we),
    .waddr_o    (upd_waddr),
    .wdata_o    (upd_wdata),
    .count_o    (upd_count),
    .result_o   (upd_result)
  );

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_tally_d = hit_tally_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      wvt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          rd_idx_d = '0;
          hit_d    = 1'b0;
          state_d  = wvt_pkg::ST_SCAN;
        end
      end
      wvt_pkg::ST_SCAN: begin
        if (match) begin
          hit_d       = 1'b1;
          hit_idx_d   = cmp_idx_q;
          hit_tally_d = rdata_q[wvt_pkg::TALLY_W-1:0];
          state_d     = wvt_pkg::ST_UPDATE;
        end else if (issue_en) begin
          rd_idx_d  = rd_idx_q + CW'(1);
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = wvt_pkg::ST_UPDATE;
        end
      end
      wvt_pkg::ST_UPDATE: begin
        if (out_free) begin
          count_d     = upd_count;
          out_valid_d = 1'b1;
          state_d     = wvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wvt_pkg::ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    hit_tally_q <= hit_tally_d;
    cmp_idx_q   <= rd_idx_q[IW-1:0];
    if (accept) begin
      vote_q <= in_data_i;
    end
    if (commit) begin
      out_q <= upd_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && upd_we) begin
      mem[upd_waddr] <= upd_wdata;
    end
    if (issue_en) begin
      rdata_q <= mem[rd_idx_q[IW-1:0]];
    end
  end

endmodule

// ----- tb/weighted_vote_tally_table_test.sv -----
`timescale 1ns / 100ps

module weighted_vote_tally_table_test;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = DEPTH + 16;

  logic clk;
  logic rst_n = 1'b0;
  logic vote_valid = 1'b0;
  logic vote_stall;
  wvt_pkg::in_t vote_beat = '0;
  logic tally_valid;
  logic tally_stall = 1'b0;
  wvt_pkg::out_t tally_beat;

  logic [wvt_pkg::ADDR_W-1:0] book_addr [DEPTH];
  logic [wvt_pkg::TALLY_W-1:0] book_tally [DEPTH];
  int unsigned book_used = 0;
  wvt_pkg::out_t tally_due [$];

  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  int unsigned holdoff_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned n_votes = 0;
  int unsigned n_checked = 0;
  int unsigned n_created = 0;
  int unsigned n_dropped = 0;
  int unsigned n_ceiling = 0;

  weighted_vote_tally_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(vote_valid),
    .in_stall_o(vote_stall),
    .in_data_i(vote_beat),
    .out_valid_o(tally_valid),
    .out_stall_i(tally_stall),
    .out_data_o(tally_beat)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic wvt_pkg::out_t tally_vote(wvt_pkg::in_t vote);
    wvt_pkg::out_t r;
    int hit;
    int k;
    int unsigned sum;
    r = '0;
    hit = -1;
    for (k = 0; k < int'(book_used); k++) begin
      if (book_addr[k] == vote.reported_address) begin
        hit = k;
        break;
      end
    end
    if (hit >= 0) begin
      sum = book_tally[hit] + vote.weight;
      if (sum > wvt_pkg::TALLY_MAX) sum = wvt_pkg::TALLY_MAX;
      book_tally[hit] = wvt_pkg::TALLY_W'(sum);
      r.slot = wvt_pkg::SLOT_W'(hit);
      r.tally = wvt_pkg::TALLY_W'(sum);
    end else if (book_used < DEPTH) begin
      book_addr[book_used] = vote.reported_address;
      book_tally[book_used] = wvt_pkg::TALLY_W'(vote.weight);
      r.slot = wvt_pkg::SLOT_W'(book_used);
      r.tally = wvt_pkg::TALLY_W'(vote.weight);
      r.created = 1'b1;
      book_used++;
    end else begin
      r.dropped = 1'b1;
    end
    r.used_entries = wvt_pkg::USED_W'(book_used);
    return r;
  endfunction

  function automatic logic [wvt_pkg::ADDR_W-1:0] rand_addr();
    return wvt_pkg::ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic void check_tally(wvt_pkg::out_t got);
    wvt_pkg::out_t want;
    if (tally_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result with nothing pending: slot=%0d tally=%0d created=%0b",
                 $realtime, got.slot, got.tally, got.created,
                 " dropped=%0b used=%0d", got.dropped, got.used_entries);
      return;
    end
    want = tally_due.pop_front();
    n_checked++;
    n_created += want.created;
    n_dropped += want.dropped;
    if (want.tally == wvt_pkg::TALLY_MAX) n_ceiling++;
    if (got.slot !== want.slot || got.tally !== want.tally || got.created !== want.created ||
        got.dropped !== want.dropped || got.used_entries !== want.used_entries) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch on result %0d", $realtime, n_checked);
        $display("  expected slot=%0d tally=%0d created=%0b dropped=%0b used=%0d",
                 want.slot, want.tally, want.created, want.dropped, want.used_entries);
        $display("  actual   slot=%0d tally=%0d created=%0b dropped=%0b used=%0d",
                 got.slot, got.tally, got.created, got.dropped, got.used_entries);
      end
    end
  endfunction

  initial begin : tally_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && tally_valid && !tally_stall) begin
        check_tally(tally_beat);
        hold = steady_out ? 0 : $urandom_range(0, 7);
      end else if (rst_n && tally_valid && hold > 0) begin
        hold--;
      end
      tally_stall <= (hold > 0) || (holdoff_left > 0);
    end
  end

  always @(posedge clk) begin
    if (holdoff_left > 0) holdoff_left <= holdoff_left - 1;
  end

  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic cast_vote(input logic [wvt_pkg::ADDR_W-1:0] addr,
                           input logic [wvt_pkg::WEIGHT_W-1:0] weight);
    wvt_pkg::in_t vote;
    int unsigned gap;
    vote.reported_address = addr;
    vote.weight = weight;
    gap = steady_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      vote_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vote_valid <= 1'b1;
    vote_beat <= vote;
    do @(posedge clk); while (vote_stall);
    tally_due.push_back(tally_vote(vote));
    n_votes++;
  endtask

  task automatic settle();
    vote_valid <= 1'b0;
    wait (tally_due.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_first_votes();
    cast_vote('0, 7'd0);
    cast_vote('0, 7'd127);
    cast_vote({wvt_pkg::ADDR_W{1'b1}}, 7'd100);
    cast_vote({wvt_pkg::ADDR_W{1'b1}}, 7'd101);
    cast_vote(48'h5555_5555_5555, 7'd1);
    cast_vote(48'hAAAA_AAAA_AAAA, 7'd64);
    cast_vote(48'h0000_0000_0001, 7'd0);
    cast_vote(48'h8000_0000_0000, 7'd127);
    cast_vote({wvt_pkg::ADDR_W{1'b1}} ^ 48'h1, 7'd50);
    cast_vote('0, 7'd0);
    cast_vote(48'h0000_0000_0001, 7'd127);
    cast_vote(48'hAAAA_AAAA_AAAA, 7'd63);
    cast_vote(48'h5555_5555_5554, 7'd99);
    settle();
  endtask

  task automatic test_tally_saturation();
    steady_out = 1'b1;
    while (book_tally[0] != wvt_pkg::TALLY_MAX)
      cast_vote('0, wvt_pkg::WEIGHT_W'($urandom_range(96, 127)));
    steady_out = 1'b0;
    repeat (6) cast_vote('0, wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
    settle();
  endtask

  task automatic test_table_fill();
    int unsigned pick;
    int unsigned k;
    while (book_used < DEPTH) begin
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, book_used - 1);
      if (pick < 4)
        cast_vote(book_addr[k], wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
      else if (pick < 6)
        cast_vote(book_addr[k] ^ (wvt_pkg::ADDR_W'(1) <<
                                  $urandom_range(0, wvt_pkg::ADDR_W - 1)),
                  wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
      else
        cast_vote(rand_addr(), wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
    end
    settle();
  endtask

  task automatic test_full_table();
    int unsigned i;
    cast_vote(book_addr[DEPTH-1], 7'd127);
    cast_vote(book_addr[0], 7'd0);
    cast_vote(rand_addr(), 7'd127);
    cast_vote(book_addr[DEPTH-1] ^ 48'h1, 7'd5);
    settle();
    // hold the output side while votes keep coming
    holdoff_left <= 400;
    steady_in = 1'b1;
    for (i = 0; i < 16; i++) begin
      if (i[0])
        cast_vote(rand_addr(), wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
      else
        cast_vote(book_addr[$urandom_range(0, DEPTH - 1)],
                  wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
    end
    steady_in = 1'b0;
    settle();
  endtask

  task automatic test_random_votes();
    int unsigned i;
    int unsigned k;
    for (i = 0; i < 800; i++) begin
      if (i % 100 == 0) begin
        steady_in = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
      end
      k = $urandom_range(0, DEPTH - 1);
      case ($urandom_range(0, 7))
        0: cast_vote(rand_addr(), wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
        1: cast_vote(book_addr[k] ^ (wvt_pkg::ADDR_W'(1) <<
                                     $urandom_range(0, wvt_pkg::ADDR_W - 1)),
                     wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
        default: cast_vote(book_addr[k], wvt_pkg::WEIGHT_W'($urandom_range(0, 127)));
      endcase
    end
    steady_in = 1'b0;
    steady_out = 1'b0;
    settle();
  endtask

  initial begin : run
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_first_votes();
    test_tally_saturation();
    test_table_fill();
    test_full_table();
    test_random_votes();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d votes: %0d created entries, %0d dropped on a full table,",
             n_votes, n_created, n_dropped, " %0d at the tally ceiling.", n_ceiling);
    $display("Checked %0d results in %0d cycles, %0d mismatches.",
             n_checked, cycle_count, mismatches);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- weighted_vote_tally_table.f -----
sv/wvt_pkg.sv
sv/wvt_update.sv
sv/weighted_vote_tally_table.sv
tb/weighted_vote_tally_table_test.sv
